// ===== rtl/rlfwd_pkg.sv =====
package rlfwd_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_SHORT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic push;
    logic mul;
    logic acc;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_take;
    logic left_zero;
    logic fill_zero;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/rlfwd_ctrl.sv =====
module rlfwd_ctrl
  import rlfwd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // first cycle after a request: decide push or take
        if (!stat.is_take) begin
          state_next = ST_DONE;
        end else if (stat.left_zero || stat.fill_zero) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (stat.left_zero || stat.fill_zero) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_PUSH: begin
        cmd.push = !stat.is_take;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
      end
      ST_DONE: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/rlfwd_dp.sv =====
module rlfwd_dp
  import rlfwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_type,
  input  logic [31:0] item_value,
  input  logic [31:0] item_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] taken_sum,
  output logic [1:0]  status,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat
);

  logic [31:0] run_values [QUEUE_DEPTH];
  logic [31:0] run_counts [QUEUE_DEPTH];

  logic [IDX_W-1:0]  head_index;
  logic [IDX_W-1:0]  tail_index;
  logic [FILL_W-1:0] fill_level;

  logic        kind;
  logic [31:0] value;
  logic [31:0] left;
  logic [63:0] sum;
  logic [63:0] product;
  logic [1:0]  push_status;

  logic [31:0] rd_value;
  logic [31:0] rd_count;

  logic             take_all;
  logic [31:0]      mult_b;
  logic             full;
  logic             push_ok;
  logic             cnt_we;
  logic [IDX_W-1:0] cnt_addr;
  logic [31:0]      cnt_wdata;
  logic [64:0]      sum_wide;

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
    wrap_next = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign full     = (fill_level == FILL_W'(QUEUE_DEPTH));
  assign push_ok  = cmd.push && (left != '0) && !full;
  assign take_all = (left >= rd_count);
  assign mult_b   = take_all ? rd_count : left;
  assign sum_wide = {1'b0, sum} + {1'b0, product};

  // count store: tail on push, head when the front run is split
  assign cnt_we    = push_ok || (cmd.mul && !take_all);
  assign cnt_addr  = cmd.mul ? head_index : tail_index;
  assign cnt_wdata = cmd.mul ? (rd_count - left) : left;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      run_values[tail_index] <= value;
    end
    if (cnt_we) begin
      run_counts[cnt_addr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_value <= run_values[head_index];
    rd_count <= run_counts[head_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0;
      tail_index <= '0;
      fill_level <= '0;
    end else begin
      if (push_ok) begin
        tail_index <= wrap_next(tail_index);
        fill_level <= fill_level + 1'b1;
      end
      if (cmd.mul && take_all) begin
        head_index <= wrap_next(head_index);
        fill_level <= fill_level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind        <= req_type;
      value       <= item_value;
      left        <= item_count;
      sum         <= '0;
      push_status <= STAT_OK;
    end
    if (cmd.push && (left != '0) && full) begin
      push_status <= STAT_FULL;
    end
    if (cmd.mul) begin
      product <= 64'(rd_value) * 64'(mult_b);
      left    <= take_all ? (left - rd_count) : '0;
    end
    if (cmd.acc) begin
      sum <= sum_wide[64] ? '1 : sum_wide[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (kind == REQ_TAKE) begin
        taken_sum <= sum;
        status    <= (left != '0) ? STAT_SHORT : STAT_OK;
      end else begin
        taken_sum <= '0;
        status    <= push_status;
      end
    end
  end

  assign stat.is_take    = (kind == REQ_TAKE);
  assign stat.left_zero  = (left == '0);
  assign stat.fill_zero  = (fill_level == '0);
  assign stat.out_free   = !out_valid || out_ready;

endmodule

// ===== rtl/run_length_fifo_weighted_drain.sv =====
// Queue of up to QUEUE_DEPTH runs (value, repeat count) with one result per
// request. A push appends a run at the tail (count 0 is ignored, a full queue
// drops it with status 1); a take removes item_count items from the front and
// returns the saturating 64-bit sum of value times items taken, splitting the
// last run touched, with status 2 when it asked for more than was stored. A
// push passes through the decide (ST_PUSH) and done states; a take passes
// through ST_PUSH, then a 32x32 multiply (ST_MUL) followed by a registered
// accumulate (ST_ACC) for every run it touches, with the front run read from
// the registered run store, and then the done state. A new request is
// accepted while the previous result still waits in the output register.
module run_length_fifo_weighted_drain
  import rlfwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [31:0] item_value,
  input  logic [31:0] item_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] taken_sum,
  output logic [1:0]  status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rlfwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rlfwd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .req_type   (req_type),
    .item_value (item_value),
    .item_count (item_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .taken_sum  (taken_sum),
    .status     (status),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ===== dv/tb_top.sv =====
module tb_top
  import rlfwd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        kind;
    logic [31:0] value;
    logic [31:0] count;
  } run_req_t;

  typedef struct {
    logic [63:0] sum;
    logic [1:0]  stat;
  } drain_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = REQ_PUSH;
  logic [31:0] item_value = '0;
  logic [31:0] item_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] taken_sum;
  logic [1:0]  status;

  run_req_t      pending_reqs[$];
  drain_result_t expected_results[$];

  // shadow copy of the run queue
  logic [31:0]       shadow_val[QUEUE_DEPTH];
  logic [31:0]       shadow_cnt[QUEUE_DEPTH];
  logic [IDX_W-1:0]  shadow_head = '0;
  logic [IDX_W-1:0]  shadow_tail = '0;
  logic [FILL_W-1:0] shadow_fill = '0;

  int  err_count = 0;
  int  n_accepted = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  int  hold_left = 0;
  bit  held_once = 1'b0;
  bit  calm = 1'b0;

  run_length_fifo_weighted_drain dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .item_value (item_value),
    .item_count (item_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .taken_sum  (taken_sum),
    .status     (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  task automatic drain_predict(input run_req_t r);
    drain_result_t res;
    logic [31:0]   left;
    logic [31:0]   used;
    logic [63:0]   prod;
    logic [64:0]   wide;
    res.sum  = '0;
    res.stat = STAT_OK;
    if (r.kind == REQ_PUSH) begin
      if (r.count != '0) begin
        if (shadow_fill == FILL_W'(QUEUE_DEPTH)) begin
          res.stat = STAT_FULL;
        end else begin
          shadow_val[shadow_tail] = r.value;
          shadow_cnt[shadow_tail] = r.count;
          shadow_tail = idx_next(shadow_tail);
          shadow_fill = shadow_fill + 1'b1;
        end
      end
    end else begin
      left = r.count;
      while (left != '0 && shadow_fill != '0) begin
        if (left >= shadow_cnt[shadow_head]) begin
          used = shadow_cnt[shadow_head];
          prod = {32'd0, shadow_val[shadow_head]} * {32'd0, used};
          shadow_head = idx_next(shadow_head);
          shadow_fill = shadow_fill - 1'b1;
        end else begin
          used = left;
          prod = {32'd0, shadow_val[shadow_head]} * {32'd0, used};
          shadow_cnt[shadow_head] = shadow_cnt[shadow_head] - left;
        end
        wide = {1'b0, res.sum} + {1'b0, prod};
        res.sum = wide[64] ? '1 : wide[63:0];
        left = left - used;
      end
      if (left != '0) res.stat = STAT_SHORT;
    end
    expected_results.insert(expected_results.size(), res);
  endtask

  task automatic add_req(input logic kind, input logic [31:0] value, input logic [31:0] count);
    run_req_t r;
    r.kind  = kind;
    r.value = value;
    r.count = count;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2, 3:    return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // sender: holds a request until accepted, random gaps between requests
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        run_req_t cur;
        cur.kind  = req_type;
        cur.value = item_value;
        cur.count = item_count;
        drain_predict(cur);
        n_accepted = n_accepted + 1;
      end
      calm = (pending_reqs.size() < 150);
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 12) - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          run_req_t nxt;
          nxt = pending_reqs.pop_front();
          req_type   <= nxt.kind;
          item_value <= nxt.value;
          item_count <= nxt.count;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result, random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing pending: taken_sum %h status %0d", taken_sum, status);
          err_count = err_count + 1;
        end else begin
          drain_result_t want;
          want = expected_results.pop_front();
          if (taken_sum !== want.sum) begin
            $error("taken_sum mismatch: expected %h, actual %h", want.sum, taken_sum);
            err_count = err_count + 1;
          end
          if (status !== want.stat) begin
            $error("status mismatch: expected %0d, actual %0d", want.stat, status);
            err_count = err_count + 1;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (!held_once && n_accepted >= 300) begin
        // long hold-off so the block backs up and stalls its input
        held_once = 1'b1;
        hold_left = 400;
        out_ready <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall = recv_stall - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int push_pct;
    int n;
    // directed: empty queue, zero counts, extremes, split run, full queue
    add_req(REQ_TAKE, '0, '0);
    add_req(REQ_TAKE, 32'h1234_5678, 32'd5);
    add_req(REQ_PUSH, 32'hdead_beef, '0);
    add_req(REQ_PUSH, '1, '1);
    add_req(REQ_PUSH, '1, '1);
    add_req(REQ_TAKE, '0, '1);
    add_req(REQ_PUSH, '0, 32'd7);
    add_req(REQ_PUSH, '1, 32'd1);
    add_req(REQ_TAKE, '1, 32'd3);
    add_req(REQ_TAKE, '0, 32'd100);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      add_req(REQ_PUSH, (i % 3 == 0) ? '1 : $urandom, $urandom_range(1, 4));
    end
    add_req(REQ_PUSH, 32'h5a5a_a5a5, 32'd9);
    add_req(REQ_PUSH, 32'h5a5a_a5a5, '0);
    add_req(REQ_TAKE, '0, '0);
    add_req(REQ_TAKE, '0, '1);

    // random: phases that lean toward filling or draining the queue
    n = 0;
    push_pct = 60;
    while (n < 1350) begin
      if (n % 50 == 0) push_pct = $urandom_range(25, 80);
      if ($urandom_range(1, 100) <= push_pct) begin
        case ($urandom_range(0, 9))
          0:       add_req(REQ_PUSH, pick_value(), '0);
          1:       add_req(REQ_PUSH, pick_value(), $urandom);
          default: add_req(REQ_PUSH, pick_value(), $urandom_range(1, 8));
        endcase
      end else begin
        case ($urandom_range(0, 9))
          0:       add_req(REQ_TAKE, $urandom, '0);
          1:       add_req(REQ_TAKE, $urandom, $urandom);
          2:       add_req(REQ_TAKE, $urandom, $urandom_range(25, 200));
          default: add_req(REQ_TAKE, $urandom, $urandom_range(1, 24));
        endcase
      end
      n = n + 1;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (50) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      err_count = err_count + 1;
    end
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
